// File: rtl/pid_speed_controller_core_defines.svh
// assertion macros shared by the pid speed controller rtl
`ifndef PID_SPEED_CONTROLLER_CORE_DEFINES_SVH
`define PID_SPEED_CONTROLLER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PIDSC_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("pidsc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PIDSC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("pidsc: next-cycle check failed");

`endif

// File: rtl/pidsc_pkg.sv
package pidsc_pkg;

    // field widths
    localparam int VEL_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int SP_W    = 9;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int DRIVE_W = 9;
    localparam int ACC_W   = 36;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAG_W   = 15;

    // setpoint clamp
    localparam logic signed [SP_W-1:0] SETPOINT_MAX = 9'sd255;
    localparam logic signed [SP_W-1:0] SETPOINT_MIN = -9'sd255;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_P_GAIN = 2'd1,
        CFG_I_GAIN = 2'd2,
        CFG_D_GAIN = 2'd3
    } cfg_reg_t;

endpackage

// File: rtl/pid_speed_controller_core.sv
// pid speed controller core
// input channel: in_valid/in_ready carry one transaction per control period with
// measured_velocity, new_setpoint and load_setpoint. output channel:
// out_valid/out_ready return drive_command and output_limited, one result per
// input transaction, in order.
// configuration: cfg_wr_en/cfg_index/cfg_wdata write enable (0), p_gain (1),
// i_gain (2) and d_gain (3); write only while no transaction is in flight.
// path: an accepted input passes through the input register, then the pid
// datapath into the result register, from which it is taken.
// throughput: 1 transaction per cycle while out_ready is high; the loop state
// (setpoint, integral, last error) is updated in the same cycle as the result
// register, so the next transaction sees it without a bubble.
// reset: rst_n clears the valid flags, gains, enable and loop state to zero;
// no results are pending afterwards.
// stall: when out_ready is low the result register holds, one more transaction
// waits in the input register, then in_ready drops until the result is taken.
`include "pid_speed_controller_core_defines.svh"

module pid_speed_controller_core #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int DRIVE_LIMIT    = 255,
    parameter int SUM_LIMIT      = 32767
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // configuration
    input  logic                                       cfg_wr_en,
    input  logic [pidsc_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]           cfg_wdata,
    // input channel
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic signed [pidsc_pkg::VEL_W-1:0]         measured_velocity,
    input  logic signed [pidsc_pkg::VEL_W-1:0]         new_setpoint,
    input  logic                                       load_setpoint,
    // output channel
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic signed [pidsc_pkg::DRIVE_W-1:0]       drive_command,
    output logic                                       output_limited
);

    localparam int ACC_W = pidsc_pkg::ACC_W;
    localparam int MAG_W = pidsc_pkg::MAG_W;
    localparam logic [ACC_W:0] ROUND_HALF = (ACC_W'(1) << GAIN_FRAC_BITS) >> 1;
    localparam logic signed [pidsc_pkg::DIFF_W-1:0] SUM_HI = pidsc_pkg::DIFF_W'(SUM_LIMIT);
    localparam logic signed [pidsc_pkg::DIFF_W-1:0] SUM_LO = -SUM_HI;
    localparam logic signed [pidsc_pkg::VEL_W-1:0] SUM_MAX = pidsc_pkg::VEL_W'(SUM_LIMIT);
    localparam logic signed [pidsc_pkg::VEL_W-1:0] SUM_MIN = -SUM_MAX;
    localparam logic [ACC_W:0] DRV_LIM_W = (ACC_W + 1)'(DRIVE_LIMIT);
    localparam logic [pidsc_pkg::DRIVE_W-1:0] DRV_POS = pidsc_pkg::DRIVE_W'(DRIVE_LIMIT);
    localparam logic [pidsc_pkg::DRIVE_W-1:0] DRV_NEG = pidsc_pkg::DRIVE_W'(-DRIVE_LIMIT);

    // configuration registers
    logic                                    enable_reg;
    logic signed [pidsc_pkg::GAIN_W-1:0]     p_gain_reg;
    logic signed [pidsc_pkg::GAIN_W-1:0]     i_gain_reg;
    logic signed [pidsc_pkg::GAIN_W-1:0]     d_gain_reg;

    // input stage
    logic                                    s1_valid_reg;
    logic signed [pidsc_pkg::VEL_W-1:0]      meas_reg;
    logic signed [pidsc_pkg::VEL_W-1:0]      newsp_reg;
    logic                                    load_reg;

    // loop state
    logic signed [pidsc_pkg::SP_W-1:0]       target_speed_reg;
    logic signed [pidsc_pkg::SP_W-1:0]       target_speed_next;
    logic signed [pidsc_pkg::VEL_W-1:0]      error_sum_reg;
    logic signed [pidsc_pkg::VEL_W-1:0]      error_sum_next;
    logic signed [pidsc_pkg::ERR_W-1:0]      prev_error_reg;
    logic signed [pidsc_pkg::ERR_W-1:0]      prev_error_next;

    // result stage
    logic                                    out_valid_reg;
    logic signed [pidsc_pkg::DRIVE_W-1:0]    drive_reg;
    logic signed [pidsc_pkg::DRIVE_W-1:0]    drive_next;
    logic                                    limited_reg;
    logic                                    limited_next;

    // datapath
    logic                                    s2_fire;
    logic signed [pidsc_pkg::SP_W-1:0]       sp_clamped;
    logic signed [pidsc_pkg::SP_W-1:0]       target_eff;
    logic signed [pidsc_pkg::ERR_W-1:0]      err;
    logic signed [pidsc_pkg::DIFF_W-1:0]     err_diff;
    logic signed [pidsc_pkg::DIFF_W-1:0]     sum_raw;
    logic signed [pidsc_pkg::VEL_W-1:0]      sum_clamped;
    logic signed [32:0]                      prod_p;
    logic signed [31:0]                      prod_i;
    logic signed [33:0]                      prod_d;
    logic signed [ACC_W-1:0]                 acc;
    logic                                    acc_neg;
    logic [ACC_W-1:0]                        acc_mag;
    logic [ACC_W:0]                          rnd;
    logic [ACC_W:0]                          q_mag;
    logic                                    pid_limited;
    logic [MAG_W-1:0]                        out_mag;
    logic [MAG_W:0]                          out_signed;

    // handshake: result register advances when empty or being taken
    assign s2_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_fire;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            p_gain_reg <= '0;
            i_gain_reg <= '0;
            d_gain_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (pidsc_pkg::cfg_reg_t'(cfg_index))
                pidsc_pkg::CFG_ENABLE: enable_reg <= cfg_wdata[0];
                pidsc_pkg::CFG_P_GAIN: p_gain_reg <= cfg_wdata;
                pidsc_pkg::CFG_I_GAIN: i_gain_reg <= cfg_wdata;
                pidsc_pkg::CFG_D_GAIN: d_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg  <= measured_velocity;
            newsp_reg <= new_setpoint;
            load_reg  <= load_setpoint;
        end
    end

    // setpoint clamp and error
    always_comb
    begin
        if (newsp_reg > pidsc_pkg::VEL_W'(pidsc_pkg::SETPOINT_MAX))
        begin
            sp_clamped = pidsc_pkg::SETPOINT_MAX;
        end
        else if (newsp_reg < pidsc_pkg::VEL_W'(pidsc_pkg::SETPOINT_MIN))
        begin
            sp_clamped = pidsc_pkg::SETPOINT_MIN;
        end
        else
        begin
            sp_clamped = newsp_reg[pidsc_pkg::SP_W-1:0];
        end
        target_eff = load_reg ? sp_clamped : target_speed_reg;
        err        = pidsc_pkg::ERR_W'(target_eff) - pidsc_pkg::ERR_W'(meas_reg);
        err_diff   = pidsc_pkg::DIFF_W'(err) - pidsc_pkg::DIFF_W'(prev_error_reg);
    end

    // integral with clamp
    always_comb
    begin
        sum_raw = pidsc_pkg::DIFF_W'(error_sum_reg) + pidsc_pkg::DIFF_W'(err);
        if (sum_raw > SUM_HI)
        begin
            sum_clamped = pidsc_pkg::VEL_W'(SUM_HI);
        end
        else if (sum_raw < SUM_LO)
        begin
            sum_clamped = pidsc_pkg::VEL_W'(SUM_LO);
        end
        else
        begin
            sum_clamped = sum_raw[pidsc_pkg::VEL_W-1:0];
        end
    end

    // gain products and exact sum
    assign prod_p = 33'(err) * 33'(p_gain_reg);
    assign prod_i = 32'(sum_clamped) * 32'(i_gain_reg);
    assign prod_d = 34'(err_diff) * 34'(d_gain_reg);
    assign acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

    // round half away from zero, then saturate the magnitude
    always_comb
    begin
        acc_neg     = acc[ACC_W-1];
        acc_mag     = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
        rnd         = {1'b0, acc_mag} + ROUND_HALF;
        q_mag       = rnd >> GAIN_FRAC_BITS;
        pid_limited = q_mag > DRV_LIM_W;
        out_mag     = pid_limited ? MAG_W'(DRIVE_LIMIT) : q_mag[MAG_W-1:0];
        out_signed  = acc_neg ? -{1'b0, out_mag} : {1'b0, out_mag};
    end

    // result and next loop state
    always_comb
    begin
        if (enable_reg)
        begin
            drive_next        = out_signed[pidsc_pkg::DRIVE_W-1:0];
            limited_next      = pid_limited;
            target_speed_next = target_eff;
            error_sum_next    = sum_clamped;
            prev_error_next   = err;
        end
        else
        begin
            drive_next        = target_speed_reg;
            limited_next      = 1'b0;
            target_speed_next = target_speed_reg;
            error_sum_next    = '0;
            prev_error_next   = prev_error_reg;
        end
    end

    // loop state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= '0;
            error_sum_reg    <= '0;
            prev_error_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s2_fire)
            begin
                target_speed_reg <= target_speed_next;
                error_sum_reg    <= error_sum_next;
                prev_error_reg   <= prev_error_next;
            end
            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            drive_reg   <= drive_next;
            limited_reg <= limited_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_command  = drive_reg;
    assign output_limited = limited_reg;

    // checks
    `PIDSC_ASSERT_IMPL(a_limit_value, clk, rst_n, out_valid_reg && limited_reg, (drive_reg == DRV_POS) || (drive_reg == DRV_NEG))
    `PIDSC_ASSERT_IMPL(a_sum_range, clk, rst_n, 1'b1, (error_sum_reg <= SUM_MAX) && (error_sum_reg >= SUM_MIN))
    `PIDSC_ASSERT_NEXT(a_disabled_clears_sum, clk, rst_n, s2_fire && !enable_reg, error_sum_reg == '0)
    `PIDSC_ASSERT_IMPL(a_target_range, clk, rst_n, 1'b1, (target_speed_reg <= pidsc_pkg::SETPOINT_MAX) && (target_speed_reg >= pidsc_pkg::SETPOINT_MIN))

endmodule

// File: test/testbench.sv
module testbench;

    localparam int FRAC_BITS   = 8;
    localparam int DRIVE_MAX   = 255;
    localparam int SUM_MAX     = 32767;
    localparam int SP_MAX      = 255;
    localparam int SETTLE_CYC  = 4;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 155;

    typedef struct {
        logic signed [pidsc_pkg::DRIVE_W-1:0] drive;
        logic                                 limited;
    } drive_result_t;

    logic                                     clk;
    logic                                     rst_n;
    logic                                     cfg_wr_en;
    logic [pidsc_pkg::CFG_IDX_W-1:0]          cfg_index;
    logic [pidsc_pkg::CFG_DATA_W-1:0]         cfg_wdata;
    logic                                     in_valid;
    logic                                     in_ready;
    logic signed [pidsc_pkg::VEL_W-1:0]       measured_velocity;
    logic signed [pidsc_pkg::VEL_W-1:0]       new_setpoint;
    logic                                     load_setpoint;
    logic                                     out_valid;
    logic                                     out_ready;
    logic signed [pidsc_pkg::DRIVE_W-1:0]     drive_command;
    logic                                     output_limited;

    // idling controls shared between sender and receiver
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_cycles;

    // pid loop predictor and queue of expected drive results
    class drive_scoreboard;
        bit            loop_on;
        int            kp;
        int            ki;
        int            kd;
        int            target;
        int            err_sum;
        int            last_err;
        drive_result_t drive_q[$];
        int            errors;

        function new();
            loop_on  = 0;
            kp       = 0;
            ki       = 0;
            kd       = 0;
            target   = 0;
            err_sum  = 0;
            last_err = 0;
            errors   = 0;
        endfunction

        function int clamp_sym(int v, int lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void write_reg(pidsc_pkg::cfg_reg_t idx,
                                logic [pidsc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pidsc_pkg::CFG_ENABLE: loop_on = data[0];
                pidsc_pkg::CFG_P_GAIN: kp = int'($signed(data));
                pidsc_pkg::CFG_I_GAIN: ki = int'($signed(data));
                pidsc_pkg::CFG_D_GAIN: kd = int'($signed(data));
                default: ;
            endcase
        endfunction

        function int pending();
            return drive_q.size();
        endfunction

        // one accepted input transaction produces exactly one drive result
        function void note_input(logic signed [pidsc_pkg::VEL_W-1:0] meas,
                                 logic signed [pidsc_pkg::VEL_W-1:0] sp, logic ld);
            drive_result_t r;
            int            e;
            int            s;
            longint        acc;
            longint        mag;
            longint        q;
            longint        half;
            r.limited = 1'b0;
            if (!loop_on)
            begin
                err_sum = 0;
                r.drive = pidsc_pkg::DRIVE_W'(target);
            end
            else
            begin
                if (ld)
                    target = clamp_sym(int'(sp), SP_MAX);
                e = target - int'(meas);
                s = clamp_sym(err_sum + e, SUM_MAX);
                acc = longint'(e) * kp + longint'(s) * ki + longint'(e - last_err) * kd;
                err_sum  = s;
                last_err = e;
                // round magnitude half away from zero
                mag  = (acc < 0) ? -acc : acc;
                half = (FRAC_BITS > 0) ? (longint'(1) <<< (FRAC_BITS - 1)) : 0;
                q    = (mag + half) >>> FRAC_BITS;
                if (acc < 0)
                    q = -q;
                if (q > DRIVE_MAX)
                begin
                    q = DRIVE_MAX;
                    r.limited = 1'b1;
                end
                else if (q < -DRIVE_MAX)
                begin
                    q = -DRIVE_MAX;
                    r.limited = 1'b1;
                end
                r.drive = pidsc_pkg::DRIVE_W'(q);
            end
            drive_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic signed [pidsc_pkg::DRIVE_W-1:0] drive, logic limited);
            drive_result_t r;
            if (drive_q.size() == 0)
            begin
                report($sformatf("unexpected result drive=%0d limited=%0b", drive, limited));
            end
            else
            begin
                r = drive_q.pop_front();
                if (drive !== r.drive)
                    report($sformatf("drive_command %0d, predicted %0d", drive, r.drive));
                if (limited !== r.limited)
                    report($sformatf("output_limited %0b, predicted %0b", limited, r.limited));
            end
        endtask

        task check_empty();
            if (drive_q.size() != 0)
                report($sformatf("%0d predicted results never arrived", drive_q.size()));
        endtask
    endclass

    drive_scoreboard sb = new();

    pid_speed_controller_core #(
        .GAIN_FRAC_BITS (FRAC_BITS),
        .DRIVE_LIMIT    (DRIVE_MAX),
        .SUM_LIMIT      (SUM_MAX)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .measured_velocity (measured_velocity),
        .new_setpoint      (new_setpoint),
        .load_setpoint     (load_setpoint),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive_command     (drive_command),
        .output_limited    (output_limited)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver readiness: random stall bursts and requested long holds
    initial
    begin : rx_ready_gen
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                n = hold_cycles;
                hold_cycles = 0;
                repeat (n - 1) @(negedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(drive_command, output_limited);
        end
    end

    // one input transaction, with an optional idle burst in front
    task send_item(logic signed [pidsc_pkg::VEL_W-1:0] meas,
                   logic signed [pidsc_pkg::VEL_W-1:0] sp, logic ld);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid          <= 1'b1;
        measured_velocity <= meas;
        new_setpoint      <= sp;
        load_setpoint     <= ld;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(meas, sp, ld);
        @(negedge clk);
    endtask

    // stop offering and wait for every predicted result
    task drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // write all four registers on consecutive cycles, block idle
    task apply_config(logic en, logic signed [15:0] p, logic signed [15:0] i,
                      logic signed [15:0] d);
        pidsc_pkg::cfg_reg_t              regs [4];
        logic [pidsc_pkg::CFG_DATA_W-1:0] vals [4];
        regs[0] = pidsc_pkg::CFG_ENABLE;
        regs[1] = pidsc_pkg::CFG_P_GAIN;
        regs[2] = pidsc_pkg::CFG_I_GAIN;
        regs[3] = pidsc_pkg::CFG_D_GAIN;
        vals[0] = {15'($urandom), en};
        vals[1] = p;
        vals[2] = i;
        vals[3] = d;
        for (int k = 0; k < 4; k++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[k];
            cfg_wdata <= vals[k];
            sb.write_reg(regs[k], vals[k]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function logic signed [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    function logic signed [15:0] pick_velocity();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 800)) - 400);
    endfunction

    // stimulus
    initial
    begin : stimulus
        logic en;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        in_valid          = 1'b0;
        measured_velocity = '0;
        new_setpoint      = '0;
        load_setpoint     = 1'b0;
        tx_idle_on        = 1'b1;
        rx_idle_on        = 1'b1;
        hold_cycles       = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // disabled after reset: load and velocity are ignored
        send_item(16'sd100, 16'sd200, 1'b1);
        send_item(16'sh8000, 16'sh7fff, 1'b0);
        drain_results();

        // unity p gain: setpoint clamp and drive saturation edges
        apply_config(1'b1, 16'sd256, 16'sd0, 16'sd0);
        send_item(16'sd0, 16'sh7fff, 1'b1);
        send_item(-16'sd1, 16'sd0, 1'b0);
        send_item(16'sd0, 16'sd255, 1'b1);
        send_item(16'sd0, 16'sd256, 1'b1);
        send_item(16'sd0, 16'sh8000, 1'b1);
        send_item(16'sd1, -16'sd255, 1'b1);
        send_item(16'sh7fff, 16'sd0, 1'b1);
        send_item(16'sh8000, 16'sd0, 1'b0);
        drain_results();

        // half gain: exact halves round away from zero
        apply_config(1'b1, 16'sd128, 16'sd0, 16'sd0);
        send_item(-16'sd1, 16'sd0, 1'b1);
        send_item(16'sd1, 16'sd0, 1'b0);
        send_item(-16'sd3, 16'sd0, 1'b0);
        send_item(16'sd3, 16'sd0, 1'b0);
        send_item(-16'sd2, 16'sd0, 1'b0);
        drain_results();

        // extreme gains, integral driven into both clamps
        apply_config(1'b1, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_item(16'sh8000, 16'sd255, 1'b1);
        send_item(16'sh8000, 16'sd255, 1'b0);
        send_item(16'sh7fff, -16'sd255, 1'b1);
        send_item(16'sh7fff, -16'sd255, 1'b0);
        drain_results();
        apply_config(1'b1, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_item(16'sd0, 16'sd0, 1'b0);
        send_item(16'sh8000, 16'sd17, 1'b1);
        drain_results();

        // disabled again: stored setpoint out, integral cleared
        apply_config(1'b0, 16'sd0, 16'sd0, 16'sd0);
        send_item(16'sd5, 16'sd100, 1'b1);
        drain_results();

        // derivative sees the error kept across the disabled step
        apply_config(1'b1, 16'sd0, 16'sd0, 16'sd256);
        send_item(16'sd0, 16'sd0, 1'b0);
        send_item(16'sd10, 16'sd0, 1'b0);
        drain_results();

        // random phases with fresh gains each time
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            en = ($urandom_range(0, 6) != 0);
            if (ph == 1)
                apply_config(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
            else if (ph == 3)
                apply_config(1'b1, 16'sh8000, 16'sh8000, 16'sh8000);
            else
                apply_config(en, pick_gain(), pick_gain(), pick_gain());
            tx_idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == 20)
                    hold_cycles = 60;
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_item(pick_velocity(),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'(int'($urandom_range(0, 600)) - 300),
                          ($urandom_range(0, 3) == 0));
            end
            drain_results();
        end

        sb.check_empty();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
